[sv/rpfb_pkg.sv]
`default_nettype none
package rpfb_pkg;

  localparam int FRAME_BYTES   = 28;
  localparam int PAYLOAD_BYTES = 19;
  localparam int POS_W         = 5;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [7:0] CRC_POLY  = 8'hD5;
  localparam logic [7:0] CRC_MSB   = 8'h80;
  localparam logic [7:0] SOF_DOLLAR = 8'h24;
  localparam logic [7:0] SOF_X      = 8'h58;
  localparam logic [7:0] SOF_DIR    = 8'h3C;
  localparam logic [7:0] FLAG_BYTE  = 8'h00;
  localparam logic [7:0] LEN_LO     = 8'(PAYLOAD_BYTES);
  localparam logic [7:0] LEN_HI     = 8'h00;

  // Byte positions within one frame
  localparam logic [POS_W-1:0] POS_SOF0    = 5'd0;
  localparam logic [POS_W-1:0] POS_SOF1    = 5'd1;
  localparam logic [POS_W-1:0] POS_SOF2    = 5'd2;
  localparam logic [POS_W-1:0] POS_FLAG    = 5'd3;
  localparam logic [POS_W-1:0] POS_CMD_LO  = 5'd4;
  localparam logic [POS_W-1:0] POS_CMD_HI  = 5'd5;
  localparam logic [POS_W-1:0] POS_LEN_LO  = 5'd6;
  localparam logic [POS_W-1:0] POS_LEN_HI  = 5'd7;
  localparam logic [POS_W-1:0] POS_PAYLOAD = 5'd8;
  localparam logic [POS_W-1:0] POS_CRC     = 5'(FRAME_BYTES - 1);

  // Register indexes of the configuration port
  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_COMMAND = 2'd1;
  localparam logic [1:0] REG_ARMED   = 2'd2;

  localparam logic [19:0] TIMEOUT_RESET = 20'd5000;
  localparam logic [15:0] COMMAND_RESET = 16'd4107;
  localparam logic [7:0]  ARMED_RESET   = 8'd1;

  localparam logic signed [31:0] ALT_SCALE   = 32'sd100;
  // floor(x / 10) == (x * 6554) >> 16 for every 12-bit x
  localparam logic [25:0]        COURSE_RECIP = 26'd6554;
  localparam logic [7:0]         QUALITY_MAX  = 8'd4;

  typedef struct packed {
    logic [19:0] link_timeout;
    logic [15:0] command_id;
    logic [7:0]  armed_mask;
  } rpfb_cfg_t;

  typedef logic [PAYLOAD_BYTES-1:0][7:0] rpfb_payload_t;

endpackage
`default_nettype wire

[sv/radar_position_frame_builder_unit.sv]
`default_nettype none
// Radar position frame builder. Each accepted request (one peer position
// record) becomes a 28-byte framed message on the output channel, one byte
// per request there, with last high on the closing CRC-8 byte. The frame is
// '$' 'X' '<', flag 0, command word, length 19, the 19-byte payload and a
// CRC-8 (poly 0xD5, init 0) over flag through payload. A record is held in
// the front end register, where its fields are converted and the link
// quality graded on the way into a small record queue, so new records are
// taken while a frame is still going out, until the queue fills; the back end
// serializer sends one byte per cycle while out_ready allows it. When the
// queue is empty, the first byte of a frame passes the front end register,
// a queue entry and the output byte register. Configuration writes are
// registered and must be made while no frame is in flight.
module radar_position_frame_builder_unit
  import rpfb_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write_en,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [19:0]       cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        slot_id,
  input  wire logic [7:0]        peer_flags,
  input  wire logic signed [31:0] latitude,
  input  wire logic signed [31:0] longitude,
  input  wire logic signed [15:0] altitude_m,
  input  wire logic [11:0]       course_tenths,
  input  wire logic [15:0]       ground_speed,
  input  wire logic [31:0]       last_seen_ms,
  input  wire logic [31:0]       now_ms,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_byte,
  output logic                   last
);

  rpfb_cfg_t     cfg;
  logic          push_valid;
  logic          push_ready;
  rpfb_payload_t push_data;
  logic          pop_valid;
  logic          pop_ready;
  rpfb_payload_t pop_data;

  // Hold configuration; writes to an unused index drop silently
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.link_timeout <= TIMEOUT_RESET;
      cfg.command_id   <= COMMAND_RESET;
      cfg.armed_mask   <= ARMED_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_TIMEOUT: cfg.link_timeout <= cfg_data;
        REG_COMMAND: cfg.command_id   <= cfg_data[15:0];
        REG_ARMED:   cfg.armed_mask   <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: capture the record, convert fields, grade the link
  rpfb_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .slot_id       (slot_id),
    .peer_flags    (peer_flags),
    .latitude      (latitude),
    .longitude     (longitude),
    .altitude_m    (altitude_m),
    .course_tenths (course_tenths),
    .ground_speed  (ground_speed),
    .last_seen_ms  (last_seen_ms),
    .now_ms        (now_ms),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_data     (push_data)
  );

  // Record queue: lets the front accept while a frame is still going out
  rpfb_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back end: serialize the frame and run the CRC; pop after the CRC byte
  rpfb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last      (last)
  );

endmodule
`default_nettype wire

[sv/rpfb_front.sv]
`default_nettype none
module rpfb_front
  import rpfb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rpfb_cfg_t         cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        slot_id,
  input  wire logic [7:0]        peer_flags,
  input  wire logic signed [31:0] latitude,
  input  wire logic signed [31:0] longitude,
  input  wire logic signed [15:0] altitude_m,
  input  wire logic [11:0]       course_tenths,
  input  wire logic [15:0]       ground_speed,
  input  wire logic [31:0]       last_seen_ms,
  input  wire logic [31:0]       now_ms,
  output logic                   push_valid,
  input  wire logic              push_ready,
  output rpfb_payload_t          push_data
);

  logic               s1_valid;
  logic [7:0]         s1_slot;
  logic [7:0]         s1_flags;
  logic [31:0]        s1_lat;
  logic [31:0]        s1_lon;
  logic signed [15:0] s1_alt;
  logic [11:0]        s1_course;
  logic [15:0]        s1_speed;
  logic [31:0]        s1_age;

  logic               accept;
  logic signed [31:0] alt_ext;
  logic signed [31:0] alt_cm;
  logic [25:0]        course_prod;
  logic [15:0]        heading;
  logic               expired;
  logic [21:0]        age_x4;
  logic [21:0]        t1;
  logic [21:0]        t2;
  logic [21:0]        t3;
  logic [7:0]         bucket;
  logic [7:0]         quality;
  logic [7:0]         armed;

  assign accept     = in_valid && in_ready;
  assign in_ready   = !s1_valid || push_ready;
  assign push_valid = s1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (push_ready) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_slot   <= slot_id;
      s1_flags  <= peer_flags;
      s1_lat    <= latitude;
      s1_lon    <= longitude;
      s1_alt    <= altitude_m;
      s1_course <= course_tenths;
      s1_speed  <= ground_speed;
      s1_age    <= now_ms - last_seen_ms;
    end
  end

  assign alt_ext     = {{16{s1_alt[15]}}, s1_alt};
  assign alt_cm      = alt_ext * ALT_SCALE;
  assign course_prod = {14'd0, s1_course} * COURSE_RECIP;
  assign heading     = {6'd0, course_prod[25:16]};

  // Age is below the timeout whenever quality is nonzero, so 20 bits suffice
  assign expired = (cfg.link_timeout == '0) || (s1_age >= {12'd0, cfg.link_timeout});
  assign age_x4  = {s1_age[19:0], 2'b00};
  assign t1      = {2'b00, cfg.link_timeout};
  assign t2      = {1'b0, cfg.link_timeout, 1'b0};
  assign t3      = t1 + t2;

  always_comb begin
    priority if (age_x4 >= t3) begin
      bucket = 8'd3;
    end else if (age_x4 >= t2) begin
      bucket = 8'd2;
    end else if (age_x4 >= t1) begin
      bucket = 8'd1;
    end else begin
      bucket = 8'd0;
    end
  end

  assign quality = expired ? 8'd0 : (QUALITY_MAX - bucket);
  assign armed   = ((s1_flags & cfg.armed_mask) != '0) ? 8'd1 : 8'd0;

  always_comb begin
    push_data[0]  = s1_slot;
    push_data[1]  = armed;
    push_data[2]  = s1_lat[7:0];
    push_data[3]  = s1_lat[15:8];
    push_data[4]  = s1_lat[23:16];
    push_data[5]  = s1_lat[31:24];
    push_data[6]  = s1_lon[7:0];
    push_data[7]  = s1_lon[15:8];
    push_data[8]  = s1_lon[23:16];
    push_data[9]  = s1_lon[31:24];
    push_data[10] = alt_cm[7:0];
    push_data[11] = alt_cm[15:8];
    push_data[12] = alt_cm[23:16];
    push_data[13] = alt_cm[31:24];
    push_data[14] = heading[7:0];
    push_data[15] = heading[15:8];
    push_data[16] = s1_speed[7:0];
    push_data[17] = s1_speed[15:8];
    push_data[18] = quality;
  end

endmodule
`default_nettype wire

[sv/rpfb_queue.sv]
`default_nettype none
module rpfb_queue
  import rpfb_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire rpfb_payload_t push_data,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output rpfb_payload_t      pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rpfb_payload_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

[sv/rpfb_back.sv]
`default_nettype none
module rpfb_back
  import rpfb_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire rpfb_cfg_t     cfg,
  input  wire logic          pop_valid,
  output logic               pop_ready,
  input  wire rpfb_payload_t pop_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_byte,
  output logic               last
);

  function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      v = ((v & CRC_MSB) != '0) ? ((v << 1) ^ CRC_POLY) : (v << 1);
    end
    return v;
  endfunction

  logic [POS_W-1:0] pos;
  logic [7:0]       crc;
  logic             advance;
  logic             at_end;
  logic             in_crc;
  logic [POS_W-1:0] pay_idx;
  logic [7:0]       byte_sel;

  assign advance   = pop_valid && (!out_valid || out_ready);
  assign at_end    = (pos == POS_CRC);
  assign pop_ready = advance && at_end;
  assign in_crc    = (pos >= POS_FLAG) && (pos < POS_CRC);
  assign pay_idx   = pos - POS_PAYLOAD;

  always_comb begin
    priority if (pos == POS_SOF0) begin
      byte_sel = SOF_DOLLAR;
    end else if (pos == POS_SOF1) begin
      byte_sel = SOF_X;
    end else if (pos == POS_SOF2) begin
      byte_sel = SOF_DIR;
    end else if (pos == POS_FLAG) begin
      byte_sel = FLAG_BYTE;
    end else if (pos == POS_CMD_LO) begin
      byte_sel = cfg.command_id[7:0];
    end else if (pos == POS_CMD_HI) begin
      byte_sel = cfg.command_id[15:8];
    end else if (pos == POS_LEN_LO) begin
      byte_sel = LEN_LO;
    end else if (pos == POS_LEN_HI) begin
      byte_sel = LEN_HI;
    end else if (pos < POS_CRC) begin
      byte_sel = pop_data[pay_idx];
    end else begin
      byte_sel = crc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      crc       <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
      pos       <= at_end ? '0 : pos + 1'b1;
      if (at_end) begin
        crc <= '0;
      end else if (in_crc) begin
        crc <= crc_update(crc, byte_sel);
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_byte <= byte_sel;
      last     <= at_end;
    end
  end

endmodule
`default_nettype wire
